[hdl/i8u_pkg.sv]
// shared types and constants of the iso-8859 to utf-8 transcoder
package i8u_pkg;

   localparam int unsigned TableEntries = 128;
   localparam int unsigned IndexWidth   = $clog2(TableEntries);
   localparam int unsigned CodeWidth    = 21;
   localparam int unsigned ByteWidth    = 8;

   localparam logic [0:0]           CMD_LOAD    = 1'b0;
   localparam logic [0:0]           CMD_CONVERT = 1'b1;
   localparam logic [CodeWidth-1:0] CODE_MAX    = 21'h10FFFF;
   localparam logic [CodeWidth-1:0] TWO_BYTE_MIN   = 21'h000080;
   localparam logic [CodeWidth-1:0] THREE_BYTE_MIN = 21'h000800;
   localparam logic [CodeWidth-1:0] FOUR_BYTE_MIN  = 21'h010000;

   // looked-up request handed from the table stage to the serializer
   typedef struct packed {
      logic                 valid;
      logic                 is_low;
      logic [ByteWidth-1:0] text_byte;
      logic [CodeWidth-1:0] code;
   } lookup_type;

endpackage

[hdl/i8u_table.sv]
// code point table with per-entry valid bits and the lookup stage
module i8u_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [0:0]                         command,
   input  logic [i8u_pkg::IndexWidth-1:0]     map_index,
   input  logic [i8u_pkg::CodeWidth-1:0]      map_code,
   input  logic [i8u_pkg::ByteWidth-1:0]      text_byte,
   input  logic                               take,
   output i8u_pkg::lookup_type                lookup
);

   logic [i8u_pkg::CodeWidth-1:0] mem [i8u_pkg::TableEntries];
   logic [i8u_pkg::TableEntries-1:0] entry_valid_ff;

   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   logic [i8u_pkg::CodeWidth-1:0] rd_data_ff;
   logic                          rd_valid_ff;
   logic [i8u_pkg::ByteWidth-1:0] text_byte_ff;

   logic do_load;
   logic do_read;
   logic [i8u_pkg::IndexWidth-1:0] rd_addr;

   assign do_load = accept && (command == i8u_pkg::CMD_LOAD) && (map_code <= i8u_pkg::CODE_MAX);
   assign do_read = accept && (command == i8u_pkg::CMD_CONVERT);
   assign rd_addr = text_byte[i8u_pkg::IndexWidth-1:0];

   always_comb begin
      if (do_read) begin
         stage_valid_in = 1'b1;
      end else if (take) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (do_load) begin
            entry_valid_ff[map_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         mem[map_index] <= map_code;
      end
      if (do_read) begin
         rd_data_ff   <= mem[rd_addr];
         rd_valid_ff  <= entry_valid_ff[rd_addr];
         text_byte_ff <= text_byte;
      end
   end

   // an entry never written reads as unmapped
   always_comb begin
      lookup.valid     = stage_valid_ff;
      lookup.is_low    = ~text_byte_ff[i8u_pkg::ByteWidth-1];
      lookup.text_byte = text_byte_ff;
      lookup.code      = rd_valid_ff ? rd_data_ff : '0;
   end

endmodule

[hdl/i8u_serializer.sv]
// utf-8 encoder that sends one byte of a character per cycle while the receiver does not stall
module i8u_serializer (
   input  logic                          clock,
   input  logic                          reset,
   input  i8u_pkg::lookup_type           lookup,
   output logic                          take,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [i8u_pkg::ByteWidth-1:0] rsp_out_byte,
   output logic [i8u_pkg::CodeWidth-1:0] rsp_code_point,
   output logic                          rsp_last_byte,
   output logic                          rsp_unmapped_error
);

   logic                          busy_ff, busy_in;
   logic [i8u_pkg::CodeWidth-1:0] cp_ff, cp_in;
   logic [1:0]                    last_idx_ff, last_idx_in;
   logic [1:0]                    idx_ff, idx_in;
   logic                          err_ff, err_in;

   logic       last;
   logic       fire;
   logic [1:0] remain;
   logic [5:0] cont;

   assign last = (idx_ff == last_idx_ff);
   assign take = !busy_ff || (last && !rsp_stall);
   assign fire = take && lookup.valid;

   always_comb begin
      busy_in     = busy_ff;
      cp_in       = cp_ff;
      last_idx_in = last_idx_ff;
      idx_in      = idx_ff;
      err_in      = err_ff;
      if (fire) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
         if (lookup.is_low) begin
            cp_in  = {{(i8u_pkg::CodeWidth-i8u_pkg::ByteWidth){1'b0}}, lookup.text_byte};
            err_in = 1'b0;
         end else begin
            cp_in  = lookup.code;
            err_in = (lookup.code == '0);
         end
         if (cp_in < i8u_pkg::TWO_BYTE_MIN) begin
            last_idx_in = 2'd0;
         end else if (cp_in < i8u_pkg::THREE_BYTE_MIN) begin
            last_idx_in = 2'd1;
         end else if (cp_in < i8u_pkg::FOUR_BYTE_MIN) begin
            last_idx_in = 2'd2;
         end else begin
            last_idx_in = 2'd3;
         end
      end else if (busy_ff && !rsp_stall) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff       <= cp_in;
      last_idx_ff <= last_idx_in;
      idx_ff      <= idx_in;
      err_ff      <= err_in;
   end

   // continuation bytes count six bits each from the low end
   assign remain = last_idx_ff - idx_ff;

   always_comb begin
      case (remain)
         2'd0:    cont = cp_ff[5:0];
         2'd1:    cont = cp_ff[11:6];
         2'd2:    cont = cp_ff[17:12];
         default: cont = {3'b000, cp_ff[20:18]};
      endcase
   end

   always_comb begin
      if (idx_ff == 2'd0) begin
         case (last_idx_ff)
            2'd0:    rsp_out_byte = {1'b0, cp_ff[6:0]};
            2'd1:    rsp_out_byte = {3'b110, cp_ff[10:6]};
            2'd2:    rsp_out_byte = {4'b1110, cp_ff[15:12]};
            default: rsp_out_byte = {5'b11110, cp_ff[20:18]};
         endcase
      end else begin
         rsp_out_byte = {2'b10, cont};
      end
   end

   assign rsp_valid          = busy_ff;
   assign rsp_code_point     = cp_ff;
   assign rsp_last_byte      = last;
   assign rsp_unmapped_error = err_ff;

endmodule

[hdl/iso8859_to_utf8_transcoder.sv]
// top level of the iso-8859 to utf-8 transcoder
// a convert request passes the table read stage, then the serializer registers, before its first byte
// requests: one request per cycle while the serializer keeps up; a character of
// several utf-8 bytes, up to four, holds the table read stage until its last byte
// is sent by the one-byte-per-cycle serializer, and a receiver stall holds it too
// reset: synchronous; clears the 128 table valid bits at once, table reads zero
module iso8859_to_utf8_transcoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [0:0]                            req_command,
   input  logic [i8u_pkg::IndexWidth-1:0]        req_map_index,
   input  logic [i8u_pkg::CodeWidth-1:0]         req_map_code,
   input  logic [i8u_pkg::ByteWidth-1:0]         req_text_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [i8u_pkg::ByteWidth-1:0]         rsp_out_byte,
   output logic [i8u_pkg::CodeWidth-1:0]         rsp_code_point,
   output logic                                  rsp_last_byte,
   output logic                                  rsp_unmapped_error
);

   i8u_pkg::lookup_type lookup;
   logic                take;
   logic                accept;

   // a pending lookup that the serializer cannot take holds off all requests
   assign req_stall = lookup.valid && !take;
   assign accept    = req_valid && !req_stall;

   i8u_table u_table (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_command),
      .map_index (req_map_index),
      .map_code  (req_map_code),
      .text_byte (req_text_byte),
      .take      (take),
      .lookup    (lookup)
   );

   i8u_serializer u_serializer (
      .clock              (clock),
      .reset              (reset),
      .lookup             (lookup),
      .take               (take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_code_point     (rsp_code_point),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_unmapped_error (rsp_unmapped_error)
   );

endmodule

[tb/testbench.sv]
// self-checking testbench for the iso-8859 to utf-8 transcoder
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [i8u_pkg::IndexWidth-1:0] index_type;
   typedef logic [i8u_pkg::CodeWidth-1:0]  code_type;
   typedef logic [i8u_pkg::ByteWidth-1:0]  byte_type;

   typedef struct packed {
      byte_type out_byte;
      code_type code_point;
      logic     last_byte;
      logic     unmapped_error;
   } utf8_byte_type;

   typedef struct packed {
      logic [0:0]    command;
      index_type     map_index;
      code_type      map_code;
      byte_type      text_byte;
      logic          typed;
      utf8_byte_type want;
   } request_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [0:0] req_command = i8u_pkg::CMD_LOAD;
   index_type  req_map_index = '0;
   code_type   req_map_code = '0;
   byte_type   req_text_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   byte_type   rsp_out_byte;
   code_type   rsp_code_point;
   logic       rsp_last_byte;
   logic       rsp_unmapped_error;

   code_type      code_map [i8u_pkg::TableEntries] = '{default: '0};
   utf8_byte_type pending_utf8 [$];
   int            mismatch_count = 0;
   int            stall_left = 0;
   logic          stall_phase = 1'b0;

   iso8859_to_utf8_transcoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_map_index      (req_map_index),
      .req_map_code       (req_map_code),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_code_point     (rsp_code_point),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_unmapped_error (rsp_unmapped_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // directed requests: extremes, every utf-8 length, surrogates, ignored loads
   request_type directed_rows [25] = '{
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h80, 1'b1, '{8'h00, 21'h000000, 1'b1, 1'b1}},
      '{i8u_pkg::CMD_CONVERT, 7'h7F, 21'h1FFFFF, 8'hFF, 1'b1, '{8'h00, 21'h000000, 1'b1, 1'b1}},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h00, 1'b1, '{8'h00, 21'h000000, 1'b1, 1'b0}},
      '{i8u_pkg::CMD_CONVERT, 7'h55, 21'h0AAAAA, 8'h7F, 1'b1, '{8'h7F, 21'h00007F, 1'b1, 1'b0}},
      '{i8u_pkg::CMD_LOAD,    7'h00, 21'h000041, 8'hFF, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h80, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h7F, 21'h10FFFF, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'hFF, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h01, 21'h000080, 8'h81, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h01, 21'h000000, 8'h81, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h02, 21'h0007FF, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h82, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h03, 21'h000800, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h83, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h04, 21'h00D800, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h84, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h05, 21'h00FFFF, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h85, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h06, 21'h010000, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h86, 1'b0, '0},
      // codes beyond unicode leave the entry alone
      '{i8u_pkg::CMD_LOAD,    7'h7F, 21'h1FFFFF, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h7F, 21'h110000, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'hFF, 1'b0, '0},
      '{i8u_pkg::CMD_LOAD,    7'h00, 21'h000000, 8'h00, 1'b0, '0},
      '{i8u_pkg::CMD_CONVERT, 7'h00, 21'h000000, 8'h80, 1'b1, '{8'h00, 21'h000000, 1'b1, 1'b1}}
   };

   function automatic void push_utf8(byte_type b, code_type cp, logic last, logic err);
      utf8_byte_type r;
      r = '{b, cp, last, err};
      pending_utf8.push_back(r);
   endfunction

   // table update on a load, utf-8 bytes of the character on a convert
   function automatic void predict_utf8(request_type rq);
      code_type cp;
      if (rq.command == i8u_pkg::CMD_LOAD) begin
         if (rq.map_code <= i8u_pkg::CODE_MAX) code_map[rq.map_index] = rq.map_code;
         return;
      end
      if (!rq.text_byte[7]) begin
         push_utf8(rq.text_byte, code_type'(rq.text_byte), 1'b1, 1'b0);
         return;
      end
      cp = code_map[rq.text_byte[6:0]];
      if (cp == '0) begin
         push_utf8('0, '0, 1'b1, 1'b1);
      end else if (cp < i8u_pkg::TWO_BYTE_MIN) begin
         push_utf8(cp[7:0], cp, 1'b1, 1'b0);
      end else if (cp < i8u_pkg::THREE_BYTE_MIN) begin
         push_utf8({3'b110, cp[10:6]}, cp, 1'b0, 1'b0);
         push_utf8({2'b10, cp[5:0]}, cp, 1'b1, 1'b0);
      end else if (cp < i8u_pkg::FOUR_BYTE_MIN) begin
         push_utf8({4'b1110, cp[15:12]}, cp, 1'b0, 1'b0);
         push_utf8({2'b10, cp[11:6]}, cp, 1'b0, 1'b0);
         push_utf8({2'b10, cp[5:0]}, cp, 1'b1, 1'b0);
      end else begin
         push_utf8({5'b11110, cp[20:18]}, cp, 1'b0, 1'b0);
         push_utf8({2'b10, cp[17:12]}, cp, 1'b0, 1'b0);
         push_utf8({2'b10, cp[11:6]}, cp, 1'b0, 1'b0);
         push_utf8({2'b10, cp[5:0]}, cp, 1'b1, 1'b0);
      end
   endfunction

   // most table traffic stays in a small window so converts hit loaded entries
   function automatic index_type pick_index();
      if ($urandom_range(0, 3) == 0)
         return index_type'($urandom_range(0, i8u_pkg::TableEntries - 1));
      return index_type'($urandom_range(0, 15));
   endfunction

   function automatic code_type pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return code_type'($urandom_range(32'h110000, 32'h1FFFFF));
      if (r < 31) return code_type'($urandom_range(32'h1, 32'h7F));
      if (r < 51) return code_type'($urandom_range(32'h80, 32'h7FF));
      if (r < 71) return code_type'($urandom_range(32'h800, 32'hFFFF));
      if (r < 76) return code_type'($urandom_range(32'hD800, 32'hDFFF));
      return code_type'($urandom_range(32'h10000, 32'h10FFFF));
   endfunction

   function automatic request_type random_request();
      request_type rq;
      rq = '0;
      rq.map_index = index_type'($urandom());
      rq.map_code  = code_type'($urandom());
      rq.text_byte = byte_type'($urandom());
      if ($urandom_range(0, 3) == 0) begin
         rq.command   = i8u_pkg::CMD_LOAD;
         rq.map_index = pick_index();
         rq.map_code  = pick_code();
      end else begin
         rq.command = i8u_pkg::CMD_CONVERT;
         if ($urandom_range(0, 9) < 3) rq.text_byte = byte_type'($urandom_range(0, 127));
         else rq.text_byte = {1'b1, pick_index()};
      end
      return rq;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(request_type rq);
      int gap;
      req_valid     <= 1'b1;
      req_command   <= rq.command;
      req_map_index <= rq.map_index;
      req_map_code  <= rq.map_code;
      req_text_byte <= rq.text_byte;
      do @(posedge clock); while (req_stall);
      if (rq.typed) push_utf8(rq.want.out_byte, rq.want.code_point, rq.want.last_byte,
                              rq.want.unmapped_error);
      else predict_utf8(rq);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_utf8.size() != 0) @(posedge clock);
   endtask

   task automatic flag_mismatch(string msg);
      if (mismatch_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // receiver stalls in bursts, with stretches of no stall at all
   always @(posedge clock) begin
      int r;
      if (stall_left <= 0) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            stall_phase = 1'b0;
            stall_left  = $urandom_range(1, 20);
         end else if (r < 90) begin
            stall_phase = 1'b1;
            stall_left  = $urandom_range(1, 3);
         end else begin
            stall_phase = 1'b1;
            stall_left  = $urandom_range(8, 40);
         end
      end
      stall_left = stall_left - 1;
      rsp_stall <= stall_phase;
   end

   always @(posedge clock) begin
      utf8_byte_type got;
      utf8_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_byte, rsp_code_point, rsp_last_byte, rsp_unmapped_error};
         if (pending_utf8.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, out_byte %h", got.out_byte));
         end else begin
            want = pending_utf8.pop_front();
            if (got.out_byte !== want.out_byte)
               flag_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
            if (got.code_point !== want.code_point)
               flag_mismatch($sformatf("code_point %h, expected %h",
                                       got.code_point, want.code_point));
            if (got.last_byte !== want.last_byte)
               flag_mismatch($sformatf("last_byte %b, expected %b",
                                       got.last_byte, want.last_byte));
            if (got.unmapped_error !== want.unmapped_error)
               flag_mismatch($sformatf("unmapped_error %b, expected %b",
                                       got.unmapped_error, want.unmapped_error));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) send_request(directed_rows[i]);
      for (int n = 0; n < 450; n++) begin
         // now and then hold off until every pending byte is out
         if (n == 150 || n == 300) wait_drained();
         send_request(random_request());
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (pending_utf8.size() == 0 && mismatch_count == 0) begin
         $display("PASS iso8859_to_utf8_transcoder");
      end else begin
         $display("FAIL iso8859_to_utf8_transcoder");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout at %0t", $realtime);
      $display("FAIL iso8859_to_utf8_transcoder");
      $finish;
   end

endmodule

[filelist.f]
hdl/i8u_pkg.sv
hdl/i8u_table.sv
hdl/i8u_serializer.sv
hdl/iso8859_to_utf8_transcoder.sv
tb/testbench.sv
